### rtl/dopt_pkg.sv
package dopt_pkg;

    // Width of a light level in whole lux.
    localparam int LUX_BITS = 17;

    localparam int DAY_W   = 24;
    localparam int CNT_W   = 16;
    localparam int DEB_W   = 8;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [DAY_W-1:0]    DAY_CYCLE_RST  = DAY_W'(60000);
    localparam logic [CNT_W-1:0]    CHECK_INT_RST  = CNT_W'(10000);
    localparam logic [CNT_W-1:0]    VALVE_OPEN_RST = CNT_W'(2000);
    localparam logic [CNT_W-1:0]    LONG_PRESS_RST = CNT_W'(3000);
    localparam logic [CNT_W-1:0]    SHORT_MAX_RST  = CNT_W'(500);
    localparam logic [DEB_W-1:0]    DEBOUNCE_RST   = DEB_W'(50);
    localparam logic [CNT_W-1:0]    BLINK_HALF_RST = CNT_W'(500);
    localparam logic [LUX_BITS-1:0] THRESHOLD_RST  = LUX_BITS'(100);

    typedef enum logic [2:0] {
        REG_DAY_CYCLE  = 3'd0,
        REG_CHECK_INT  = 3'd1,
        REG_VALVE_OPEN = 3'd2,
        REG_LONG_PRESS = 3'd3,
        REG_SHORT_MAX  = 3'd4,
        REG_DEBOUNCE   = 3'd5,
        REG_BLINK_HALF = 3'd6
    } t_reg_idx;

    typedef enum logic [2:0] {
        M_IDLE  = 3'd0,
        M_DEB   = 3'd1,
        M_HOLD  = 3'd2,
        M_WREL  = 3'd3,
        M_CAL   = 3'd4,
        M_CALP  = 3'd5,
        M_PULSE = 3'd6
    } t_mode;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_FIRED   = 3'd1,
        EV_SKIPPED = 3'd2,
        EV_BELOW   = 3'd3,
        EV_MANUAL  = 3'd4,
        EV_CAL_IN  = 3'd5,
        EV_SAVED   = 3'd6
    } t_event;

    typedef struct packed {
        logic [DAY_W-1:0] day_cycle;
        logic [CNT_W-1:0] check_int;
        logic [CNT_W-1:0] valve_open;
        logic [CNT_W-1:0] long_press;
        logic [CNT_W-1:0] short_max;
        logic [DEB_W-1:0] debounce;
        logic [CNT_W-1:0] blink_half;
    } t_cfg;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == '1) ? v : v + CNT_W'(1);
    endfunction

endpackage

### rtl/dopt_regs.sv
module dopt_regs
    import dopt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg     r_cfg;
    logic     wr_en;
    t_reg_idx idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.day_cycle  <= DAY_CYCLE_RST;
            r_cfg.check_int  <= CHECK_INT_RST;
            r_cfg.valve_open <= VALVE_OPEN_RST;
            r_cfg.long_press <= LONG_PRESS_RST;
            r_cfg.short_max  <= SHORT_MAX_RST;
            r_cfg.debounce   <= DEBOUNCE_RST;
            r_cfg.blink_half <= BLINK_HALF_RST;
        end else if (wr_en) begin
            case (idx)
                REG_DAY_CYCLE:  r_cfg.day_cycle  <= pwdata[DAY_W-1:0];
                REG_CHECK_INT:  r_cfg.check_int  <= pwdata[CNT_W-1:0];
                REG_VALVE_OPEN: r_cfg.valve_open <= pwdata[CNT_W-1:0];
                REG_LONG_PRESS: r_cfg.long_press <= pwdata[CNT_W-1:0];
                REG_SHORT_MAX:  r_cfg.short_max  <= pwdata[CNT_W-1:0];
                REG_DEBOUNCE:   r_cfg.debounce   <= pwdata[DEB_W-1:0];
                REG_BLINK_HALF: r_cfg.blink_half <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (idx)
            REG_DAY_CYCLE:  prdata = DATA_W'(r_cfg.day_cycle);
            REG_CHECK_INT:  prdata = DATA_W'(r_cfg.check_int);
            REG_VALVE_OPEN: prdata = DATA_W'(r_cfg.valve_open);
            REG_LONG_PRESS: prdata = DATA_W'(r_cfg.long_press);
            REG_SHORT_MAX:  prdata = DATA_W'(r_cfg.short_max);
            REG_DEBOUNCE:   prdata = DATA_W'(r_cfg.debounce);
            REG_BLINK_HALF: prdata = DATA_W'(r_cfg.blink_half);
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

### rtl/dopt_core.sv
module dopt_core
    import dopt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [LUX_BITS-1:0] i_light_lux,
    input  logic                i_button_down,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_relay_on,
    output logic                o_led_on,
    output logic                o_manual_on,
    output logic                o_done_today,
    output logic [LUX_BITS-1:0] o_threshold_now,
    output logic [2:0]          o_event_code
);

    // Input stage.
    logic                r_in_valid;
    logic [LUX_BITS-1:0] r_in_lux;
    logic                r_in_btn;

    // Controller state.
    logic [DAY_W-1:0]    r_day_count,   n_day_count;
    logic [CNT_W-1:0]    r_check_count, n_check_count;
    t_mode               r_mode,        n_mode;
    logic [CNT_W-1:0]    r_phase_count, n_phase_count;
    logic [CNT_W-1:0]    r_blink_count, n_blink_count;
    logic                r_blink_level, n_blink_level;
    logic                r_fired_today, n_fired_today;
    logic                r_manual_mode, n_manual_mode;
    logic [LUX_BITS-1:0] r_threshold,   n_threshold;

    // Result stage.
    logic                r_out_valid;
    logic                r_out_relay,   n_out_relay;
    logic                r_out_led,     n_out_led;
    t_event              r_out_event,   n_out_event;

    logic                move;
    logic                pulse;
    logic                accept;

    // The input stage advances when the result register is empty or drained.
    assign move    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_in_valid && !move;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (move) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_lux <= i_light_lux;
            r_in_btn <= i_button_down;
        end
    end

    always_comb begin
        n_day_count   = r_day_count;
        n_check_count = sat_inc(r_check_count);
        n_mode        = r_mode;
        n_phase_count = r_phase_count;
        n_blink_count = r_blink_count;
        n_blink_level = r_blink_level;
        n_fired_today = r_fired_today;
        n_manual_mode = r_manual_mode;
        n_threshold   = r_threshold;
        n_out_event   = EV_NONE;
        pulse         = 1'b0;

        // The day counter runs in every mode.
        if ({1'b0, r_day_count} + (DAY_W+1)'(1) >= {1'b0, i_cfg.day_cycle}) begin
            n_day_count   = '0;
            n_fired_today = 1'b0;
        end else begin
            n_day_count = r_day_count + DAY_W'(1);
        end

        case (r_mode)
            M_DEB: begin
                n_phase_count = sat_inc(r_phase_count);
                if (n_phase_count >= {{(CNT_W-DEB_W){1'b0}}, i_cfg.debounce}) begin
                    n_mode        = M_HOLD;
                    n_phase_count = '0;
                end
            end
            M_HOLD: begin
                if (r_in_btn) begin
                    n_phase_count = sat_inc(r_phase_count);
                    if (n_phase_count >= i_cfg.long_press) begin
                        n_mode      = M_WREL;
                        n_out_event = EV_CAL_IN;
                    end
                end else begin
                    if (r_phase_count < i_cfg.short_max) begin
                        n_manual_mode = !r_manual_mode;
                        n_out_event   = EV_MANUAL;
                    end
                    n_mode = M_IDLE;
                end
            end
            M_WREL: begin
                if (!r_in_btn) begin
                    n_mode        = M_CAL;
                    n_blink_count = '0;
                    n_blink_level = 1'b0;
                end
            end
            M_CAL: begin
                if (r_in_btn) begin
                    n_mode        = M_CALP;
                    n_blink_level = 1'b0;
                end else begin
                    n_blink_count = sat_inc(r_blink_count);
                    if (n_blink_count >= i_cfg.blink_half) begin
                        n_blink_level = !r_blink_level;
                        n_blink_count = '0;
                    end
                end
            end
            M_CALP: begin
                if (!r_in_btn) begin
                    n_threshold   = r_in_lux;
                    n_out_event   = EV_SAVED;
                    n_check_count = '0;
                    n_mode        = M_IDLE;
                end
            end
            M_PULSE: begin
                if (r_phase_count >= i_cfg.valve_open) begin
                    n_mode = M_IDLE;
                end else begin
                    n_phase_count = sat_inc(r_phase_count);
                    pulse         = 1'b1;
                end
            end
            default: begin
                n_mode = M_IDLE;
                if (n_check_count >= i_cfg.check_int) begin
                    n_check_count = '0;
                    if (r_in_lux >= r_threshold) begin
                        // A day rollover on this same tick has already cleared the flag.
                        if (!n_fired_today) begin
                            n_fired_today = 1'b1;
                            n_out_event   = EV_FIRED;
                            n_mode        = M_PULSE;
                            n_phase_count = CNT_W'(1);
                            pulse         = 1'b1;
                        end else begin
                            n_out_event = EV_SKIPPED;
                        end
                    end else begin
                        n_out_event = EV_BELOW;
                    end
                end
                if (!pulse && r_in_btn) begin
                    n_mode        = M_DEB;
                    n_phase_count = '0;
                end
            end
        endcase

        n_out_relay = pulse || n_manual_mode;
        if (pulse) begin
            n_out_led = 1'b1;
        end else if (n_mode == M_CAL) begin
            n_out_led = n_blink_level;
        end else begin
            n_out_led = n_manual_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_day_count   <= '0;
            r_check_count <= '0;
            r_mode        <= M_IDLE;
            r_phase_count <= '0;
            r_blink_count <= '0;
            r_blink_level <= 1'b0;
            r_fired_today <= 1'b0;
            r_manual_mode <= 1'b0;
            r_threshold   <= THRESHOLD_RST;
        end else if (move) begin
            r_day_count   <= n_day_count;
            r_check_count <= n_check_count;
            r_mode        <= n_mode;
            r_phase_count <= n_phase_count;
            r_blink_count <= n_blink_count;
            r_blink_level <= n_blink_level;
            r_fired_today <= n_fired_today;
            r_manual_mode <= n_manual_mode;
            r_threshold   <= n_threshold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_relay <= n_out_relay;
            r_out_led   <= n_out_led;
            r_out_event <= n_out_event;
        end
    end

    // The flag, mode and threshold outputs are the state the last item left.
    assign o_valid         = r_out_valid;
    assign o_relay_on      = r_out_relay;
    assign o_led_on        = r_out_led;
    assign o_manual_on     = r_manual_mode;
    assign o_done_today    = r_fired_today;
    assign o_threshold_now = r_threshold;
    assign o_event_code    = r_out_event;

    a_fired_drives: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_event == EV_FIRED) |->
            (r_out_relay && r_out_led && r_fired_today && r_mode == M_PULSE))
        else $error("fired item without relay pulse");

    a_saved_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && r_mode == M_CALP && !r_in_btn) |=>
            (r_check_count == '0 && r_threshold == $past(r_in_lux)))
        else $error("threshold save did not restart the check interval");

    a_cal_entered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_event == EV_CAL_IN) |-> (r_mode == M_WREL))
        else $error("calibration event without wait-release mode");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> $stable(r_mode) && $stable(r_day_count))
        else $error("state advanced while the result was stalled");

endmodule

### rtl/daylight_once_per_day_trigger.sv
// Channel   | Handshake          | Payload
// ----------+--------------------+------------------------------------------------
// input     | i_valid / o_stall  | i_light_lux, i_button_down (one tick per item)
// result    | o_valid / i_stall  | o_relay_on, o_led_on, o_manual_on, o_done_today,
//           |                    | o_threshold_now, o_event_code
// config    | APB psel/penable   | paddr, pwdata, prdata, pready (seven registers)
//
// An item is registered on acceptance, and its result when the input stage advances,
// so one item can be accepted in every cycle while o_stall stays low.
// The controller state and the result register are written together by one pass of
// combinational logic: a few counter increments and compares.
// Reset is synchronous and active low; it loads the register defaults and clears the
// controller to idle with a threshold of 100 lux.
// A stall on the result side holds the result; the input register still takes one
// more item, after which o_stall rises until the result drains.
module daylight_once_per_day_trigger
    import dopt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [LUX_BITS-1:0] i_light_lux,
    input  logic                i_button_down,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_relay_on,
    output logic                o_led_on,
    output logic                o_manual_on,
    output logic                o_done_today,
    output logic [LUX_BITS-1:0] o_threshold_now,
    output logic [2:0]          o_event_code
);

    // Register file view shared with the controller.
    t_cfg cfg;

    dopt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // The controller holds the day, check, press and blink counters, the mode, the
    // once-per-day flag, manual mode and the stored threshold.
    dopt_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_light_lux     (i_light_lux),
        .i_button_down   (i_button_down),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_relay_on      (o_relay_on),
        .o_led_on        (o_led_on),
        .o_manual_on     (o_manual_on),
        .o_done_today    (o_done_today),
        .o_threshold_now (o_threshold_now),
        .o_event_code    (o_event_code)
    );

endmodule
